/* hw/rtl/smvig_pkg.sv */
// Shared types and constants of the sphere mesh vertex/index generator.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package smvig_pkg;

  localparam int CNT_W  = 11;
  localparam int RING_W = 11;
  localparam int SEG_W  = 10;
  localparam int IDX_W  = 21;
  localparam int TEX_W  = 17;
  localparam int POS_W  = 16;
  localparam int COL_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [0:0] REG_LON = 1'b0;
  localparam logic [0:0] REG_LAT = 1'b1;

  localparam logic [CNT_W-1:0] LON_RESET = 11'd32;
  localparam logic [CNT_W-1:0] LAT_RESET = 11'd16;

  // Odd sine polynomial over a quarter turn, Q30 coefficients.
  localparam logic [30:0] CA1  = 31'd1686629713;
  localparam logic [30:0] CA3  = 31'd693598668;
  localparam logic [30:0] CA5  = 31'd85569306;
  localparam logic [30:0] CA7  = 31'd5026995;
  localparam logic [30:0] CA9  = 31'd172272;
  localparam logic [30:0] CA11 = 31'd3864;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef logic [30:0] horner_tab_t [0:4];
  localparam horner_tab_t HORNER_CA = '{CA9, CA7, CA5, CA3, CA1};

  typedef struct packed {
    logic              kind;
    logic              second;
    logic [RING_W-1:0] ring;
    logic [SEG_W-1:0]  seg;
  } beat_meta_t;

endpackage

`default_nettype wire

/* hw/rtl/sphere_mesh_vertex_index_generator_unit.sv */
// Top level of the UV-sphere vertex and quad index generator.
// Depends on smvig_pkg for field widths, polynomial constants and the beat metadata type.
`default_nettype none

// Usage
// A request is taken at a rising edge where start is high and busy is low. It names a
// ring and a segment; in_req_type selects a vertex (0) or a quad (1). Requests that fall
// outside the configured counts, or arrive while a count is zero, are taken and dropped.
// A vertex gives one result beat: position (also the normal), texture coordinates and
// colour, with out_last set. A quad gives two beats of triangle indices, the second one
// marked by out_last.
// Each beat shows on the out_ ports for exactly one cycle with out_strobe high; the
// receiver cannot hold beats off, so nothing in the block ever stalls.
// Pipeline: the block is a 45-stage pipeline. A vertex request can be taken every cycle
// while busy is low. A quad holds busy high for the one following cycle, while its second
// triangle enters the pipeline. The depth is set by the two restoring dividers that turn
// ring and segment into angle phases, one quotient bit per stage (32 stages), followed by
// the nine-stage sine polynomial, with one multiplier in every stage but the quadrant
// reduction and the clamp, and the product, rounding and output stages.
// Configuration writes are registered and must only be made while no request is in
// flight. Reset clears all valid bits and the pending second triangle and restores the
// counts to 32 segments and 16 bands.
module sphere_mesh_vertex_index_generator_unit #(
  parameter int MAX_SEGMENTS    = 1024,
  parameter int COORD_FRAC_BITS = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [smvig_pkg::RING_W-1:0]     in_ring,
  input  logic [smvig_pkg::SEG_W-1:0]      in_segment,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_idx,
  input  logic [smvig_pkg::CNT_W-1:0]      cfg_wdata,
  output logic                             out_strobe,
  output logic signed [smvig_pkg::POS_W-1:0] out_pos_x,
  output logic signed [smvig_pkg::POS_W-1:0] out_pos_y,
  output logic signed [smvig_pkg::POS_W-1:0] out_pos_z,
  output logic [smvig_pkg::TEX_W-1:0]      out_tex_u,
  output logic [smvig_pkg::TEX_W-1:0]      out_tex_v,
  output logic [smvig_pkg::COL_W-1:0]      out_col_r,
  output logic [smvig_pkg::COL_W-1:0]      out_col_g,
  output logic [smvig_pkg::COL_W-1:0]      out_col_b,
  output logic [smvig_pkg::IDX_W-1:0]      out_idx_a,
  output logic [smvig_pkg::IDX_W-1:0]      out_idx_b,
  output logic [smvig_pkg::IDX_W-1:0]      out_idx_c,
  output logic                             out_last
);
  import smvig_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int CW   = F + 1;
  localparam int XSH  = 60 - F;
  localparam int YSH  = 30 - F;
  localparam int NDIV = 32;
  localparam int S_T0 = NDIV + 1;
  localparam int LAST = NDIV + 11;
  localparam logic [CW:0] COORD_MAX = (CW + 1)'((64'd1 << F) - 64'd1);
  localparam logic [61:0] XHALF = 62'd1 << (XSH - 1);

  // ---------------------------------------------------------------- configuration
  logic [CNT_W-1:0] lon_r, lat_r;
  logic [CNT_W-1:0] g_eff, l_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= LON_RESET;
      lat_r <= LAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LON: lon_r <= cfg_wdata;
        REG_LAT: lat_r <= cfg_wdata;
      endcase
    end
  end

  // Counts above the supported size saturate.
  assign g_eff = ({2'b00, lon_r} > 13'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : lon_r;
  assign l_eff = ({2'b00, lat_r} > 13'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : lat_r;

  // ---------------------------------------------------------------- entry
  logic              pending_r;
  logic [RING_W-1:0] held_ring_r;
  logic [SEG_W-1:0]  held_seg_r;
  logic              acc, req_ok, acc_quad, ent_vld;
  beat_meta_t        ent_meta;

  assign busy     = pending_r;
  assign acc      = start && !busy;
  assign req_ok   = (g_eff != '0) && (l_eff != '0) && ({1'b0, in_segment} < g_eff) &&
                    (in_req_type ? (in_ring < l_eff) : (in_ring <= l_eff));
  assign acc_quad = acc && req_ok && in_req_type;
  // The second triangle of a quad enters in the cycle after its request.
  assign ent_vld  = pending_r || (acc && req_ok);

  always_comb begin
    if (pending_r) begin
      ent_meta = '{kind: 1'b1, second: 1'b1, ring: held_ring_r, seg: held_seg_r};
    end else begin
      ent_meta = '{kind: in_req_type, second: 1'b0, ring: in_ring, seg: in_segment};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else begin
      pending_r <= acc_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_quad) begin
      held_ring_r <= in_ring;
      held_seg_r  <= in_segment;
    end
  end

  // ---------------------------------------------------------------- valid and metadata
  logic       vld_r  [0:LAST];
  beat_meta_t meta_r [0:LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= ent_vld;
      for (int k = 1; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= ent_meta;
    for (int k = 1; k <= LAST; k++) meta_r[k] <= meta_r[k-1];
  end

  // ---------------------------------------------------------------- phase dividers
  // Polar phase floor(i*2^31/L) and azimuth phase floor(j*2^32/G), one quotient bit
  // per stage. The integer part of each numerator is below its divisor, so it seeds
  // the remainder; the polar numerator also feeds in ring bit 0 at the first step.
  logic [CNT_W-1:0] pol_rem_r [0:NDIV];
  logic [31:0]      pol_q_r   [0:NDIV];
  logic [CNT_W-1:0] azi_rem_r [0:NDIV];
  logic [31:0]      azi_q_r   [0:NDIV];
  logic [CNT_W-1:0] pol_rem_nxt [1:NDIV];
  logic [31:0]      pol_q_nxt   [1:NDIV];
  logic [CNT_W-1:0] azi_rem_nxt [1:NDIV];
  logic [31:0]      azi_q_nxt   [1:NDIV];

  always_comb begin
    logic [CNT_W:0] psh, ash;
    logic           pge, age;
    for (int k = 1; k <= NDIV; k++) begin
      psh = {pol_rem_r[k-1], (k == 1) ? meta_r[0].ring[0] : 1'b0};
      ash = {azi_rem_r[k-1], 1'b0};
      pge = psh >= {1'b0, l_eff};
      age = ash >= {1'b0, g_eff};
      pol_rem_nxt[k] = pge ? CNT_W'(psh - {1'b0, l_eff}) : psh[CNT_W-1:0];
      azi_rem_nxt[k] = age ? CNT_W'(ash - {1'b0, g_eff}) : ash[CNT_W-1:0];
      pol_q_nxt[k]   = {pol_q_r[k-1][30:0], pge};
      azi_q_nxt[k]   = {azi_q_r[k-1][30:0], age};
    end
  end

  always_ff @(posedge clk) begin
    pol_rem_r[0] <= {1'b0, ent_meta.ring[RING_W-1:1]};
    pol_q_r[0]   <= '0;
    azi_rem_r[0] <= CNT_W'(ent_meta.seg);
    azi_q_r[0]   <= '0;
    for (int k = 1; k <= NDIV; k++) begin
      pol_rem_r[k] <= pol_rem_nxt[k];
      pol_q_r[k]   <= pol_q_nxt[k];
      azi_rem_r[k] <= azi_rem_nxt[k];
      azi_q_r[k]   <= azi_q_nxt[k];
    end
  end

  // ---------------------------------------------------------------- texture coordinates
  // Rounded i/L in Q16 equals the truncated Q17 quotient plus one, halved, so it is taken
  // straight from the phases.
  logic [TEX_W-1:0] tex_u_r [S_T0:LAST];
  logic [TEX_W-1:0] tex_v_r [S_T0:LAST];
  logic [18:0]      tu_sum;
  logic [17:0]      tv_sum;

  assign tu_sum = {1'b0, pol_q_r[NDIV][31:14]} + 19'd1;
  assign tv_sum = {1'b0, azi_q_r[NDIV][31:15]} + 18'd1;

  always_ff @(posedge clk) begin
    tex_u_r[S_T0] <= tu_sum[17:1];
    tex_v_r[S_T0] <= tv_sum[17:1];
    for (int k = S_T0 + 1; k <= LAST; k++) begin
      tex_u_r[k] <= tex_u_r[k-1];
      tex_v_r[k] <= tex_v_r[k-1];
    end
  end

  // ---------------------------------------------------------------- sine lanes
  // Lane 0 sin(polar), 1 cos(polar), 2 sin(azimuth), 3 cos(azimuth).
  logic [31:0] lane_ph  [0:3];
  logic [30:0] arg_r    [0:3][0:6];
  logic        neg_r    [0:3][0:8];
  logic [30:0] t2_r     [0:3][1:5];
  logic [30:0] s_r      [0:3][2:7];
  logic [30:0] mag_r    [0:3];
  logic [61:0] sq_p     [0:3];
  logic [61:0] h_p      [0:3][0:4];
  logic [61:0] f_p      [0:3];

  assign lane_ph[0] = pol_q_r[NDIV];
  assign lane_ph[1] = pol_q_r[NDIV] + 32'h4000_0000;
  assign lane_ph[2] = azi_q_r[NDIV];
  assign lane_ph[3] = azi_q_r[NDIV] + 32'h4000_0000;

  always_comb begin
    for (int ln = 0; ln < 4; ln++) begin
      sq_p[ln] = 62'(arg_r[ln][0]) * 62'(arg_r[ln][0]);
      h_p[ln][0] = 62'(CA11) * 62'(t2_r[ln][1]);
      for (int h = 1; h < 5; h++) begin
        h_p[ln][h] = 62'(s_r[ln][1+h]) * 62'(t2_r[ln][1+h]);
      end
      f_p[ln] = 62'(s_r[ln][6]) * 62'(arg_r[ln][6]);
    end
  end

  always_ff @(posedge clk) begin
    for (int ln = 0; ln < 4; ln++) begin
      // Quadrant reduction: odd quadrants mirror, the upper half negates.
      arg_r[ln][0] <= lane_ph[ln][30] ? (Q30_ONE - {1'b0, lane_ph[ln][29:0]})
                                      : {1'b0, lane_ph[ln][29:0]};
      neg_r[ln][0] <= lane_ph[ln][31];
      for (int r = 1; r <= 8; r++) neg_r[ln][r] <= neg_r[ln][r-1];
      for (int r = 1; r <= 6; r++) arg_r[ln][r] <= arg_r[ln][r-1];
      t2_r[ln][1] <= sq_p[ln][60:30];
      for (int r = 2; r <= 5; r++) t2_r[ln][r] <= t2_r[ln][r-1];
      for (int h = 0; h < 5; h++) s_r[ln][2+h] <= HORNER_CA[h] - h_p[ln][h][60:30];
      s_r[ln][7] <= f_p[ln][60:30];
      mag_r[ln]  <= (s_r[ln][7] > Q30_ONE) ? Q30_ONE : s_r[ln][7];
    end
  end

  // ---------------------------------------------------------------- products and rounding
  logic [60:0] x_m_r, z_m_r;
  logic [30:0] y_m_r;
  logic        x_neg_r, y_neg_r, z_neg_r;
  logic [61:0] x_p, z_p, xs, zs;
  logic [CW:0] xmag, ymag, zmag;
  logic signed [CW-1:0] x_c_r, y_c_r, z_c_r;

  assign x_p = 62'(mag_r[0]) * 62'(mag_r[2]);
  assign z_p = 62'(mag_r[0]) * 62'(mag_r[3]);

  always_ff @(posedge clk) begin
    x_m_r   <= x_p[60:0];
    z_m_r   <= z_p[60:0];
    y_m_r   <= mag_r[1];
    x_neg_r <= neg_r[0][8] ^ neg_r[2][8];
    z_neg_r <= neg_r[0][8] ^ neg_r[3][8];
    y_neg_r <= neg_r[1][8];
  end

  assign xs   = {1'b0, x_m_r} + XHALF;
  assign zs   = {1'b0, z_m_r} + XHALF;
  assign xmag = xs[61:XSH];
  assign zmag = zs[61:XSH];

  generate
    if (YSH > 0) begin : g_yround
      localparam logic [31:0] YHALF = 32'd1 << (YSH - 1);
      logic [31:0] ys;
      assign ys   = {1'b0, y_m_r} + YHALF;
      assign ymag = ys[31:YSH];
    end else begin : g_ynoround
      assign ymag = (CW + 1)'(y_m_r);
    end
  endgenerate

  // Round half away from zero has been done on the magnitude; apply the sign, and clamp positive values to COORD_MAX.
  function automatic logic [CW-1:0] coord_sat(input logic neg, input logic [CW:0] m);
    logic [CW:0] ng;
    ng = ~m + 1'b1;
    if (neg) begin
      return ng[CW-1:0];
    end else if (m > COORD_MAX) begin
      return COORD_MAX[CW-1:0];
    end else begin
      return m[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    x_c_r <= coord_sat(x_neg_r, xmag);
    y_c_r <= coord_sat(y_neg_r, ymag);
    z_c_r <= coord_sat(z_neg_r, zmag);
  end

  // ---------------------------------------------------------------- output stage
  logic signed [31:0] xw, yw, zw;
  logic [CW+15:0]     cr, cg, cb;
  logic [22:0]        p1, p2, p3, p4;
  logic               wrap;
  beat_meta_t         om;

  assign om = meta_r[LAST];
  assign xw = 32'(x_c_r);
  assign yw = 32'(y_c_r);
  assign zw = 32'(z_c_r);
  // (p + 1) / 2 in Q0.16: flipping the sign bit offsets by one, the shift scales.
  assign cr = {~x_c_r[CW-1], x_c_r[CW-2:0], 16'b0};
  assign cg = {~y_c_r[CW-1], y_c_r[CW-2:0], 16'b0};
  assign cb = {~z_c_r[CW-1], z_c_r[CW-2:0], 16'b0};

  // Segment j+1 wraps to 0 on the same ring at the seam.
  assign wrap = (12'(om.seg) + 12'd1) == 12'(g_eff);
  assign p1   = 23'(g_eff) * 23'(om.ring) + 23'(om.seg);
  assign p2   = p1 + 23'(g_eff);
  assign p4   = wrap ? (p1 - 23'(om.seg)) : (p1 + 23'd1);
  assign p3   = wrap ? (p2 - 23'(om.seg)) : (p2 + 23'd1);

  logic out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (om.kind) begin
      out_pos_x <= '0;
      out_pos_y <= '0;
      out_pos_z <= '0;
      out_tex_u <= '0;
      out_tex_v <= '0;
      out_col_r <= '0;
      out_col_g <= '0;
      out_col_b <= '0;
      out_idx_a <= p4[IDX_W-1:0];
      out_idx_b <= om.second ? p2[IDX_W-1:0] : p1[IDX_W-1:0];
      out_idx_c <= om.second ? p3[IDX_W-1:0] : p2[IDX_W-1:0];
      out_last  <= om.second;
    end else begin
      out_pos_x <= xw[POS_W-1:0];
      out_pos_y <= yw[POS_W-1:0];
      out_pos_z <= zw[POS_W-1:0];
      out_tex_u <= tex_u_r[LAST];
      out_tex_v <= tex_v_r[LAST];
      out_col_r <= cr[CW+15:CW];
      out_col_g <= cg[CW+15:CW];
      out_col_b <= cb[CW+15:CW];
      out_idx_a <= '0;
      out_idx_b <= '0;
      out_idx_c <= '0;
      out_last  <= 1'b1;
    end
  end

  assign out_strobe = out_strobe_r;

  // ---------------------------------------------------------------- assertions
  a_pending_from_quad: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> $past(acc_quad))
    else $error("second triangle pending without a taken quad");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |=> !pending_r)
    else $error("busy held for more than one cycle");

  a_quad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (out_strobe && out_last))
    else $error("first triangle not followed by second");

endmodule

`default_nettype wire

/* dv/sphere_mesh_vertex_index_generator_tb.sv */
// Self-checking testbench of the UV-sphere vertex and quad index generator.
// Depends on smvig_pkg and on sphere_mesh_vertex_index_generator_unit.
module testbench;
  import smvig_pkg::*;

  localparam int FRAC = 15;
  localparam int MAX_CNT = 1024;
  localparam int DRAIN_CYCLES = 60;     // a little over the 45-stage pipeline
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic [TEX_W-1:0] tu, tv;
    logic [COL_W-1:0] cr, cg, cb;
    logic [IDX_W-1:0] ia, ib, ic;
    logic last;
  } sphere_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [RING_W-1:0] in_ring = '0;
  logic [SEG_W-1:0] in_segment = '0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = REG_LON;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic [COL_W-1:0] out_col_r, out_col_g, out_col_b;
  logic [IDX_W-1:0] out_idx_a, out_idx_b, out_idx_c;
  logic out_last;

  sphere_beat_t beat_q[$];
  logic [CNT_W-1:0] lon_reg, lat_reg;
  int idle_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  sphere_mesh_vertex_index_generator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_ring(in_ring), .in_segment(in_segment),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_col_r(out_col_r), .out_col_g(out_col_g), .out_col_b(out_col_b),
    .out_idx_a(out_idx_a), .out_idx_b(out_idx_b), .out_idx_c(out_idx_c),
    .out_last(out_last)
  );

  // ---------------- geometry predictor ----------------

  // sin(pi/2 * t) for t in Q30 over the quarter turn, truncated Horner form.
  function automatic longint unsigned quarter_sine(longint unsigned t);
    longint unsigned t2, s;
    t2 = (t * t) >> 30;
    s = CA11;
    s = CA9 - ((s * t2) >> 30);
    s = CA7 - ((s * t2) >> 30);
    s = CA5 - ((s * t2) >> 30);
    s = CA3 - ((s * t2) >> 30);
    s = CA1 - ((s * t2) >> 30);
    s = (s * t) >> 30;
    return (s > Q30_ONE) ? longint'(Q30_ONE) : s;
  endfunction

  function automatic longint turn_sine(logic [31:0] ph);
    longint unsigned t, m;
    t = ph[29:0];
    m = ph[30] ? quarter_sine(64'd1073741824 - t) : quarter_sine(t);
    return ph[31] ? -longint'(m) : longint'(m);
  endfunction

  // Round half away from zero by sh bits, then clamp to the Q1.15 range.
  function automatic longint coord_round(longint v, int sh);
    longint unsigned m;
    longint r, lim;
    lim = 64'sd1 << FRAC;
    m = (v < 0) ? -v : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    r = (v < 0) ? -longint'(m) : longint'(m);
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] colour_of(longint p);
    longint unsigned v;
    v = ((p + (64'sd1 << FRAC)) << 16) >> (FRAC + 1);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic longint unsigned sat_count(logic [CNT_W-1:0] c);
    return (c > MAX_CNT) ? MAX_CNT : c;
  endfunction

  // Queues the beats that one accepted request must produce.
  task automatic predict_element(logic kind, logic [RING_W-1:0] ri, logic [SEG_W-1:0] sj);
    longint unsigned g, l, i, j, jn, p1, p2, p3, p4;
    logic [31:0] pol, azi;
    longint st, ct, sp, cp, x, y, z;
    sphere_beat_t b;
    g = sat_count(lon_reg);
    l = sat_count(lat_reg);
    i = ri;
    j = sj;
    b = '{default: '0};
    if (g == 0 || l == 0 || j >= g) return;
    if (kind == 1'b0) begin
      if (i > l) return;
      pol = 32'((i << 31) / l);
      azi = 32'((j << 32) / g);
      st = turn_sine(pol);
      ct = turn_sine(pol + 32'h4000_0000);
      sp = turn_sine(azi);
      cp = turn_sine(azi + 32'h4000_0000);
      x = coord_round(st * sp, 60 - FRAC);
      y = coord_round(ct, 30 - FRAC);
      z = coord_round(st * cp, 60 - FRAC);
      b.px = x[15:0];
      b.py = y[15:0];
      b.pz = z[15:0];
      b.tu = TEX_W'((2 * i * 65536 + l) / (2 * l));
      b.tv = TEX_W'((2 * j * 65536 + g) / (2 * g));
      b.cr = colour_of(x);
      b.cg = colour_of(y);
      b.cb = colour_of(z);
      b.last = 1'b1;
      beat_q = {beat_q, b};
    end else begin
      if (i >= l) return;
      // The seam wraps back to segment zero of the same ring.
      jn = (j + 1 == g) ? 0 : j + 1;
      p1 = g * i + j;
      p2 = g * (i + 1) + j;
      p3 = g * (i + 1) + jn;
      p4 = g * i + jn;
      b.ia = p4[20:0];
      b.ib = p1[20:0];
      b.ic = p2[20:0];
      b.last = 1'b0;
      beat_q = {beat_q, b};
      b.ib = p2[20:0];
      b.ic = p3[20:0];
      b.last = 1'b1;
      beat_q = {beat_q, b};
    end
  endtask

  // ---------------- result checking ----------------

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    sphere_beat_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (beat_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        e = beat_q.pop_front();
        check_field("pos_x", e.px, out_pos_x);
        check_field("pos_y", e.py, out_pos_y);
        check_field("pos_z", e.pz, out_pos_z);
        check_field("tex_u", e.tu, out_tex_u);
        check_field("tex_v", e.tv, out_tex_v);
        check_field("col_r", e.cr, out_col_r);
        check_field("col_g", e.cg, out_col_g);
        check_field("col_b", e.cb, out_col_b);
        check_field("idx_a", e.ia, out_idx_a);
        check_field("idx_b", e.ib, out_idx_b);
        check_field("idx_c", e.ic, out_idx_c);
        check_field("last", e.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  // Holds one request until it is taken, then maybe idles a few cycles.
  task automatic send_request(logic kind, logic [RING_W-1:0] ri, logic [SEG_W-1:0] sj);
    start <= 1'b1;
    in_req_type <= kind;
    in_ring <= ri;
    in_segment <= sj;
    do @(posedge clk); while (busy);
    predict_element(kind, ri, sj);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [0:0] idx, logic [CNT_W-1:0] value);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LON) lon_reg = value;
    else lat_reg = value;
  endtask

  task automatic test_reset_counts();
    send_request(1'b0, 0, 0);        // north pole
    send_request(1'b0, 16, 0);       // south pole, ring equal to the band count
    send_request(1'b0, 8, 8);        // equator
    send_request(1'b0, 5, 31);
    send_request(1'b1, 0, 0);
    send_request(1'b1, 15, 31);      // quad across the seam
    send_request(1'b0, 17, 0);       // ring past the south pole
    send_request(1'b0, 3, 32);       // segment past the last one
    send_request(1'b1, 16, 4);       // quad ring out of range
    send_request(1'b1, 2047, 1023);
    send_request(1'b0, 2047, 1023);
  endtask

  task automatic test_count_extremes();
    write_count(REG_LON, 1);
    write_count(REG_LAT, 1);
    send_request(1'b0, 0, 0);
    send_request(1'b0, 1, 0);
    send_request(1'b1, 0, 0);        // single segment wraps onto itself
    send_request(1'b1, 0, 1);
    write_count(REG_LON, 0);         // zero count drops everything
    send_request(1'b0, 0, 0);
    send_request(1'b1, 0, 0);
    write_count(REG_LON, 2047);      // saturates to the maximum
    write_count(REG_LAT, 1024);
    send_request(1'b0, 1024, 1023);
    send_request(1'b0, 512, 256);
    send_request(1'b1, 1023, 1023);
    send_request(1'b1, 1024, 0);
    write_count(REG_LAT, 0);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 0, 0);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0: return CNT_W'(MAX_CNT);
      1: return CNT_W'($urandom_range(2047, 1));
      2: return CNT_W'(1);
      default: return CNT_W'($urandom_range(40, 1));
    endcase
  endfunction

  task automatic test_random_phase(int pct, int n_items);
    longint unsigned g, l;
    logic kind;
    logic [RING_W-1:0] ri;
    logic [SEG_W-1:0] sj;
    write_count(REG_LON, pick_count());
    write_count(REG_LAT, pick_count());
    idle_pct = pct;
    g = sat_count(lon_reg);
    l = sat_count(lat_reg);
    for (int n = 0; n < n_items; n++) begin
      kind = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
        ri = RING_W'($urandom);
        sj = SEG_W'($urandom);
      end else begin
        ri = RING_W'(kind ? $urandom_range(l - 1) : $urandom_range(l));
        sj = SEG_W'($urandom_range(g - 1));
      end
      send_request(kind, ri, sj);
    end
  endtask

  initial begin
    lon_reg = LON_RESET;
    lat_reg = LAT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_counts();
    test_count_extremes();
    test_random_phase(0, 180);
    test_random_phase(48, 180);
    test_random_phase(29, 180);
    test_random_phase(0, 100);
    test_random_phase(48, 100);
    drain_pipeline();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
